// ===== rtl/ltcsa_pkg.sv =====
`default_nettype none
package ltcsa_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 32;
    localparam int TICK_W    = 32;
    localparam int SLOT_W    = 4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   item_id;
        logic [TICK_W-1:0] now_tick;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/lru_tag_cache_slot_allocator.sv =====
`default_nettype none
// lru tag cache slot allocator
//
// request channel (req_valid / req_stall / req): one transaction carries an
// operation (lookup or insert), an identifier and a tick. response channel
// (rsp_valid / rsp_stall / rsp): exactly one transaction per request, with
// the hit flag and the slot index (low 4 bits of the index).
// the request is captured, then one shared scan unit walks the slot table
// one entry per cycle through a single memory read port. the same pass does
// the identifier search and the victim search (first zero stamp, else the
// smallest stamp, lowest index on ties). the scan stops as soon as the
// answer is known; the table write happens in the final commit state.
// the scan length is set by the one-entry-per-cycle read port, and the response
// comes later while an older response is stalled. req_stall is high from
// acceptance until commit, so at most one request is in flight.
// the response register lets a new request be accepted while an earlier
// result still waits on rsp_stall; commit waits until the register is free.
// reset clears all per-row valid bits at once, so every slot reads as empty
// with a zero stamp immediately after reset; no clearing pass is needed.
module lru_tag_cache_slot_allocator
    import ltcsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  req_valid,
    output logic req_stall,
    input  wire  req_t req,
    output logic rsp_valid,
    input  wire  rsp_stall,
    output rsp_t rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    // slot table storage, no reset: row valid bits stand in for the clear
    logic [ID_W-1:0]   id_mem    [SLOTS];
    logic [TICK_W-1:0] stamp_mem [SLOTS];
    logic [SLOTS-1:0]  row_valid_reg, row_valid_next;

    logic [1:0]        state_reg, state_next;
    req_t              req_reg;
    logic [IW-1:0]     addr_reg, addr_next;
    logic              issue_done_reg, issue_done_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IW-1:0]     chk_idx_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic [TICK_W-1:0] rd_stamp_reg;
    logic              rd_row_valid_reg;

    // search and victim trackers
    logic              srch_done_reg, srch_done_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     found_idx_reg, found_idx_next;
    logic              vic_done_reg, vic_done_next;
    logic [IW-1:0]     vic_idx_reg, vic_idx_next;
    logic [TICK_W-1:0] best_stamp_reg, best_stamp_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // write port
    logic              id_we, stamp_we;
    logic [IW-1:0]     wr_idx;
    logic [TICK_W-1:0] stamp_wdata;

    logic [ID_W-1:0]   id_e;
    logic [TICK_W-1:0] stamp_e;
    logic              req_take;
    logic              commit_go;
    logic [IW-1:0]     ins_idx;
    logic [IW+3:0]     slot_ext;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // never-written rows read as empty with a zero stamp
    assign id_e    = rd_row_valid_reg ? rd_id_reg    : '0;
    assign stamp_e = rd_row_valid_reg ? rd_stamp_reg : '0;

    assign commit_go = (state_reg == ST_COMMIT) && (!rsp_valid_reg || !rsp_stall);
    assign ins_idx   = found_reg ? found_idx_reg : vic_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = 1'b0;
        srch_done_next  = srch_done_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        vic_done_next   = vic_done_reg;
        vic_idx_next    = vic_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        row_valid_next  = row_valid_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        id_we           = 1'b0;
        stamp_we        = 1'b0;
        wr_idx          = ins_idx;
        stamp_wdata     = '0;
        slot_ext        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next      = ST_SCAN;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    srch_done_next  = 1'b0;
                    found_next      = 1'b0;
                    vic_done_next   = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // read issue side: one row per cycle
                chk_valid_next = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    if (addr_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end

                // check side: row read in the previous cycle
                if (chk_valid_reg)
                begin
                    if (!srch_done_reg)
                    begin
                        if (id_e == '0)
                        begin
                            srch_done_next = 1'b1;
                        end
                        else if (id_e == req_reg.item_id)
                        begin
                            srch_done_next = 1'b1;
                            found_next     = 1'b1;
                            found_idx_next = chk_idx_reg;
                        end
                    end
                    if (!vic_done_reg)
                    begin
                        if (stamp_e == '0)
                        begin
                            vic_done_next = 1'b1;
                            vic_idx_next  = chk_idx_reg;
                        end
                        else if (chk_idx_reg == '0 || stamp_e < best_stamp_reg)
                        begin
                            best_stamp_next = stamp_e;
                            best_idx_next   = chk_idx_reg;
                        end
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        srch_done_next = 1'b1;
                        if (!vic_done_next)
                        begin
                            vic_done_next = 1'b1;
                            vic_idx_next  = best_idx_next;
                        end
                    end
                    if (srch_done_next
                        && (req_reg.operation == OP_LOOKUP || found_next || vic_done_next))
                    begin
                        state_next     = ST_COMMIT;
                        chk_valid_next = 1'b0;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next.hit   = found_reg;
                    if (req_reg.operation == OP_LOOKUP)
                    begin
                        // touch on hit
                        wr_idx      = found_idx_reg;
                        stamp_wdata = req_reg.now_tick;
                        stamp_we    = found_reg;
                        slot_ext    = found_reg ? {4'b0, found_idx_reg} : '0;
                    end
                    else
                    begin
                        wr_idx   = ins_idx;
                        id_we    = 1'b1;
                        // first write of a row also sets its stamp to zero
                        stamp_we = !row_valid_reg[ins_idx];
                        row_valid_next[ins_idx] = 1'b1;
                        slot_ext = {4'b0, ins_idx};
                    end
                    rsp_next.slot = slot_ext[SLOT_W-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_done_reg   <= 1'b0;
            chk_valid_reg    <= 1'b0;
            srch_done_reg    <= 1'b0;
            found_reg        <= 1'b0;
            vic_done_reg     <= 1'b0;
            row_valid_reg    <= '0;
            rd_row_valid_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_done_reg   <= issue_done_next;
            chk_valid_reg    <= chk_valid_next;
            srch_done_reg    <= srch_done_next;
            found_reg        <= found_next;
            vic_done_reg     <= vic_done_next;
            row_valid_reg    <= row_valid_next;
            rd_row_valid_reg <= row_valid_reg[addr_reg];
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        addr_reg       <= addr_next;
        chk_idx_reg    <= addr_reg;
        found_idx_reg  <= found_idx_next;
        vic_idx_reg    <= vic_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        rsp_reg        <= rsp_next;
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_idx] <= req_reg.item_id;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_idx] <= stamp_wdata;
        end
        rd_id_reg    <= id_mem[addr_reg];
        rd_stamp_reg <= stamp_mem[addr_reg];
    end

endmodule
`default_nettype wire

// ===== sim/lru_tag_cache_slot_allocator_test.sv =====
`timescale 1ns / 1ps

module lru_tag_cache_slot_allocator_test;
    import ltcsa_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    // limit on the whole run; the slowest correct item is a long sender gap plus
    // a full scan plus a long receiver stall
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 104;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // golden copy of the slot table
    logic [ID_W-1:0]   tbl_id    [SLOTS];
    logic [TICK_W-1:0] tbl_stamp [SLOTS];

    // transactions waiting to be sent: payload, idle cycles before it, and
    // a flag that holds it back until every outstanding response is back
    req_t pend_req[$];
    int   pend_gap[$];
    bit   pend_drain[$];

    // responses predicted at request acceptance, oldest first
    rsp_t expected_rsp[$];

    int fail_cnt  = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    int calm_left = 0;

    lru_tag_cache_slot_allocator #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the golden table and return the response it causes
    function automatic rsp_t alloc_predict(req_t r);
        int   found;
        int   victim;
        int   idx;
        rsp_t e;
        found = -1;
        // search stops at the first empty identifier
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_id[i] == '0)
                break;
            if (tbl_id[i] == r.item_id)
            begin
                found = i;
                break;
            end
        end
        e = '0;
        if (r.operation == OP_LOOKUP)
        begin
            // a lookup only touches the stamp on a hit; a miss reports slot 0
            if (found >= 0)
            begin
                tbl_stamp[found] = r.now_tick;
                e.hit  = 1'b1;
                e.slot = found[SLOT_W-1:0];
            end
            return e;
        end
        // insert miss: first zero stamp, else oldest stamp, lowest index on ties
        victim = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_stamp[i] == '0)
            begin
                victim = i;
                break;
            end
            if (tbl_stamp[i] < tbl_stamp[victim])
                victim = i;
        end
        idx = (found >= 0) ? found : victim;
        // insert writes the identifier but leaves the stamp alone
        tbl_id[idx] = r.item_id;
        e.hit  = (found >= 0);
        e.slot = idx[SLOT_W-1:0];
        return e;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_req(logic op, logic [ID_W-1:0] id, logic [TICK_W-1:0] tick,
                             int gap, bit drain);
        req_t r;
        r.operation = op;
        r.item_id   = id;
        r.now_tick  = tick;
        pend_req.push_back(r);
        pend_gap.push_back(gap);
        pend_drain.push_back(drain);
    endtask

    // request driver: the prediction is made at the edge that accepts a transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp.push_back(alloc_predict(req));
            // payload may only change once the current one is taken
            if (!req_valid || !req_stall)
            begin
                if (pend_req.size() == 0)
                    req_valid <= 1'b0;
                else if (pend_drain[0] && expected_rsp.size() != 0)
                    req_valid <= 1'b0;
                else if (pend_gap[0] > 0)
                begin
                    pend_drain[0] = 1'b0;
                    pend_gap[0]   = pend_gap[0] - 1;
                    req_valid    <= 1'b0;
                end
                else
                begin
                    req <= pend_req.pop_front();
                    void'(pend_gap.pop_front());
                    void'(pend_drain.pop_front());
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // response monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        int   r;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response with none outstanding: hit=%0d slot=%0d", rsp.hit, rsp.slot);
                    fail_cnt++;
                end
                else
                begin
                    exp_rsp = expected_rsp.pop_front();
                    if (rsp.hit !== exp_rsp.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", exp_rsp.hit, rsp.hit);
                        fail_cnt++;
                    end
                    if (rsp.slot !== exp_rsp.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", exp_rsp.slot, rsp.slot);
                        fail_cnt++;
                    end
                end
            end
            // stall pattern: calm stretches, short bursts, rare long holds
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                rsp_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    calm_left = $urandom_range(30, 120);
                    rsp_stall <= 1'b0;
                end
                else if (r < 65)
                    rsp_stall <= 1'b0;
                else if (r < 90)
                begin
                    hold_left = $urandom_range(0, 2);
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    hold_left = $urandom_range(9, 39);
                    rsp_stall <= 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [ID_W-1:0]   pool [32];
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] clock_tick;
        logic              op;
        int                pool_n;
        int                tick_mode;
        int                r;
        bit                calm;

        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_id[i]    = '0;
            tbl_stamp[i] = '0;
        end

        // directed: empty table, extremes, stale stamps, hole behind a zero insert
        queue_req(OP_LOOKUP, 32'd1,          32'd5,          pick_gap(), 1'b0); // miss on empty
        queue_req(OP_LOOKUP, 32'd0,          32'd5,          pick_gap(), 1'b0); // zero id never hits
        queue_req(OP_INSERT, 32'hFFFF_FFFF,  32'd0,          pick_gap(), 1'b0); // slot 0
        queue_req(OP_INSERT, 32'hFFFF_FFFF,  32'd0,          pick_gap(), 1'b0); // insert hit
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  pick_gap(), 1'b0); // max stamp
        queue_req(OP_INSERT, 32'd5,          32'hFFFF_FFFF,  pick_gap(), 1'b0);
        queue_req(OP_LOOKUP, 32'd5,          32'd9,          pick_gap(), 1'b0);
        queue_req(OP_INSERT, 32'd6,          32'd0,          pick_gap(), 1'b0);
        queue_req(OP_LOOKUP, 32'd6,          32'd4,          pick_gap(), 1'b0);
        queue_req(OP_INSERT, 32'd7,          32'd0,          pick_gap(), 1'b0);
        queue_req(OP_LOOKUP, 32'd7,          32'd2,          pick_gap(), 1'b0);
        // never-looked-up slot keeps stamp zero and gets picked again
        queue_req(OP_INSERT, 32'd8,          32'd0,          pick_gap(), 1'b0);
        queue_req(OP_INSERT, 32'd9,          32'd0,          pick_gap(), 1'b0);
        // tick zero on a hit clears a stamp, so the slot becomes the victim
        queue_req(OP_LOOKUP, 32'd6,          32'd0,          pick_gap(), 1'b0);
        queue_req(OP_INSERT, 32'd0,          32'd0,          pick_gap(), 1'b0); // punch hole
        queue_req(OP_LOOKUP, 32'd7,          32'd3,          pick_gap(), 1'b0); // beyond hole
        queue_req(OP_INSERT, 32'd7,          32'd0,          pick_gap(), 1'b0); // duplicate
        queue_req(OP_LOOKUP, 32'd7,          32'd11,         pick_gap(), 1'b0);
        queue_req(OP_INSERT, 32'h8000_0000,  32'hFFFF_FFFF,  pick_gap(), 1'b0);
        queue_req(OP_LOOKUP, 32'hAAAA_AAAA,  32'h5555_5555,  pick_gap(), 1'b0);
        queue_req(OP_LOOKUP, 32'h8000_0000,  32'h5555_5555,  pick_gap(), 1'b0);

        // random phases: each has its own id pool, tick style and idle style
        clock_tick = 32'd100;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            pool_n = $urandom_range(3, 24);
            for (int k = 0; k < pool_n; k++)
                pool[k] = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(1, 40)) : $urandom;
            tick_mode = $urandom_range(0, 2);
            calm      = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
                r  = $urandom_range(0, 99);
                if (r < 3)
                    id = '0;
                else if (r < 8)
                    id = $urandom;
                else
                    id = pool[$urandom_range(0, pool_n - 1)];
                case (tick_mode)
                    0:
                    begin
                        // monotonic clock, the intended use
                        clock_tick = clock_tick + 32'($urandom_range(1, 3));
                        tick = clock_tick;
                    end
                    1:       tick = 32'($urandom_range(0, 6)); // many stamp ties
                    default: tick = $urandom;
                endcase
                queue_req(op, id, tick, calm ? 0 : pick_gap(), (n == 0) && (ph % 4 == 0));
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pend_req.size() != 0 || req_valid)
            @(negedge clk);
        while (expected_rsp.size() != 0)
            @(negedge clk);
        // trailing window to catch stray responses
        repeat (SLOTS + 8) @(negedge clk);

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
